@@ rtl/can_frame_signal_extractor_unit_defines.svh @@
// Assertion macros used by the top-level RTL of the CAN frame signal extractor.
`ifndef CAN_FRAME_SIGNAL_EXTRACTOR_UNIT_DEFINES_SVH
`define CAN_FRAME_SIGNAL_EXTRACTOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define CFSX_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CFSX_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CFSX_ASSERT(label, clk, rst, prop, msg)
`define CFSX_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ rtl/cfsx_pkg.sv @@
package cfsx_pkg;

   localparam int NumSignals = 15;
   localparam int NumIdRegs  = 5;
   localparam int MaxResults = 7;

   localparam int IdxW      = $clog2(NumSignals);
   localparam int CountW    = $clog2(MaxResults + 1);
   localparam int RegSelW   = $clog2(NumIdRegs);
   localparam int IdW       = 11;
   localparam int LenW      = 4;
   localparam int PayloadW  = 64;
   localparam int ValueW    = 32;
   localparam int StartW    = 6;
   localparam int WidthW    = 6;
   localparam int SignPosW  = $clog2(ValueW);
   localparam int CsrIndexW = 3;
   localparam int CsrDataW  = 11;

   localparam logic [LenW-1:0] ExpectedLengthReset = 4'd8;

   typedef enum logic [CsrIndexW-1:0] {
      CsrImuOneAnglesId  = 3'd0,
      CsrImuTwoAnglesId  = 3'd1,
      CsrImuHeadingId    = 3'd2,
      CsrCameraStatusId  = 3'd3,
      CsrCameraControlId = 3'd4,
      CsrExpectedLength  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [RegSelW-1:0] reg_sel;
      logic [StartW-1:0]  start;
      logic [WidthW-1:0]  width_bits;
      logic               is_signed;
   } desc_type;

   typedef struct packed {
      logic            write;
      logic [IdxW-1:0] index;
   } update_type;

   function automatic desc_type desc_lookup(input logic [IdxW-1:0] idx);
      desc_type d;
      unique case (idx)
         4'd0:    d = '{3'd0, 6'd0,  6'd32, 1'b1};
         4'd1:    d = '{3'd0, 6'd32, 6'd32, 1'b1};
         4'd2:    d = '{3'd2, 6'd0,  6'd32, 1'b1};
         4'd3:    d = '{3'd1, 6'd0,  6'd32, 1'b1};
         4'd4:    d = '{3'd1, 6'd32, 6'd32, 1'b1};
         4'd5:    d = '{3'd2, 6'd32, 6'd32, 1'b1};
         4'd6:    d = '{3'd3, 6'd0,  6'd1,  1'b0};
         4'd7:    d = '{3'd3, 6'd1,  6'd1,  1'b0};
         4'd8:    d = '{3'd3, 6'd2,  6'd1,  1'b0};
         4'd9:    d = '{3'd3, 6'd3,  6'd1,  1'b0};
         4'd10:   d = '{3'd3, 6'd8,  6'd16, 1'b0};
         4'd11:   d = '{3'd3, 6'd24, 6'd16, 1'b1};
         4'd12:   d = '{3'd3, 6'd40, 6'd16, 1'b0};
         4'd13:   d = '{3'd4, 6'd16, 6'd16, 1'b0};
         4'd14:   d = '{3'd4, 6'd32, 6'd16, 1'b0};
         default: d = '{3'd0, 6'd0,  6'd32, 1'b0};
      endcase
      return d;
   endfunction

   function automatic logic [NumSignals-1:0] desc_hit_mask(input logic [NumIdRegs-1:0] hit);
      logic [NumSignals-1:0] m;
      desc_type              d;
      for (int i = 0; i < NumSignals; i++) begin
         d    = desc_lookup(IdxW'(i));
         m[i] = hit[d.reg_sel];
      end
      return m;
   endfunction

endpackage

@@ rtl/can_frame_signal_extractor_unit.sv @@
// Once a frame is accepted, descriptors are visited in table order from position 0 up to
// the last matching one, one descriptor per cycle while no stalled result holds the scan.
// Each match updates the signal value file and, up to MaxResults, is registered as a result.
// No new frame is taken until the scan ends; frames that match nothing leave the block idle.
// Reset: identifier registers clear to zero, expected length becomes 8, the signal value
// file clears to zero and no result is pending.
`include "can_frame_signal_extractor_unit_defines.svh"

module can_frame_signal_extractor_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [cfsx_pkg::IdW-1:0]            req_frame_id,
   input  logic                                req_extended,
   input  logic [cfsx_pkg::LenW-1:0]           req_length,
   input  logic [cfsx_pkg::PayloadW-1:0]       req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [cfsx_pkg::IdxW-1:0]           rsp_signal_index,
   output logic signed [cfsx_pkg::ValueW-1:0]  rsp_signal_value,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cfsx_pkg::CsrIndexW-1:0]      csr_index,
   input  logic [cfsx_pkg::CsrDataW-1:0]       csr_data
);
   import cfsx_pkg::*;

   logic [IdW-1:0]      id_ff [NumIdRegs];
   logic [IdW-1:0]      id_in [NumIdRegs];
   logic [LenW-1:0]     expected_length_ff, expected_length_in;
   logic [PayloadW-1:0] payload_ff;
   logic [ValueW-1:0]   signal_values_ff [NumSignals];

   logic [NumIdRegs-1:0] id_hit;
   logic                 frame_ok;
   logic [IdxW-1:0]      desc_index;
   logic [ValueW-1:0]    field_value;
   logic [ValueW-1:0]    rsp_value;
   update_type           update;

   assign csr_ready = 1'b1;

   always_comb begin
      id_in              = id_ff;
      expected_length_in = expected_length_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CsrImuOneAnglesId:  id_in[0] = csr_data;
            CsrImuTwoAnglesId:  id_in[1] = csr_data;
            CsrImuHeadingId:    id_in[2] = csr_data;
            CsrCameraStatusId:  id_in[3] = csr_data;
            CsrCameraControlId: id_in[4] = csr_data;
            CsrExpectedLength:  expected_length_in = csr_data[LenW-1:0];
            default:            expected_length_in = expected_length_ff;
         endcase
      end
   end

   always_comb begin
      frame_ok = !req_extended && (req_length == expected_length_ff);
      for (int k = 0; k < NumIdRegs; k++) begin
         id_hit[k] = frame_ok && (req_frame_id == id_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NumIdRegs; k++) begin
            id_ff[k] <= '0;
         end
         expected_length_ff <= ExpectedLengthReset;
      end else begin
         id_ff              <= id_in;
         expected_length_ff <= expected_length_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         payload_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NumSignals; s++) begin
            signal_values_ff[s] <= '0;
         end
      end else if (update.write) begin
         signal_values_ff[update.index] <= field_value;
      end
   end

   cfsx_field_unit u_field_unit (
      .desc_index  (desc_index),
      .payload     (payload_ff),
      .field_value (field_value)
   );

   cfsx_scan_ctrl u_scan_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .id_hit           (id_hit),
      .desc_index       (desc_index),
      .field_value      (field_value),
      .update           (update),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_signal_index (rsp_signal_index),
      .rsp_value        (rsp_value),
      .rsp_last         (rsp_last)
   );

   assign rsp_signal_value = $signed(rsp_value);

   `CFSX_ASSERT(a_update_stored, clock, reset, update.write |=> signal_values_ff[$past(update.index)] == $past(field_value), "Signal value file missed an update.")
   `CFSX_ASSERT(a_update_while_busy, clock, reset, update.write |-> !req_ready, "Signal update while the block accepts items.")
   `CFSX_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!rsp_valid && req_ready), "Block not idle after reset.")

endmodule

@@ rtl/cfsx_field_unit.sv @@
module cfsx_field_unit (
   input  logic [cfsx_pkg::IdxW-1:0]     desc_index,
   input  logic [cfsx_pkg::PayloadW-1:0] payload,
   output logic [cfsx_pkg::ValueW-1:0]   field_value
);
   import cfsx_pkg::*;

   desc_type              desc;
   logic [PayloadW-1:0]   shifted;
   logic [ValueW-1:0]     mask;
   logic [ValueW-1:0]     field;
   logic [SignPosW-1:0]   sign_pos;
   logic                  sign_fill;

   always_comb begin
      desc        = desc_lookup(desc_index);
      shifted     = payload >> desc.start;
      mask        = ~({ValueW{1'b1}} << desc.width_bits);
      field       = shifted[ValueW-1:0] & mask;
      sign_pos    = SignPosW'(desc.width_bits - WidthW'(1));
      sign_fill   = desc.is_signed && field[sign_pos];
      field_value = sign_fill ? (field | ~mask) : field;
   end

endmodule

@@ rtl/cfsx_scan_ctrl.sv @@
module cfsx_scan_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [cfsx_pkg::NumIdRegs-1:0]   id_hit,
   output logic [cfsx_pkg::IdxW-1:0]        desc_index,
   input  logic [cfsx_pkg::ValueW-1:0]      field_value,
   output cfsx_pkg::update_type             update,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [cfsx_pkg::IdxW-1:0]        rsp_signal_index,
   output logic [cfsx_pkg::ValueW-1:0]      rsp_value,
   output logic                             rsp_last
);
   import cfsx_pkg::*;

   typedef enum logic {
      StIdle,
      StScan
   } state_type;

   state_type             state_ff, state_in;
   logic [IdxW-1:0]       idx_ff, idx_in;
   logic [NumSignals-1:0] mask_ff, mask_in;
   logic [CountW-1:0]     count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IdxW-1:0]       rsp_index_ff, rsp_index_in;
   logic [ValueW-1:0]     rsp_value_ff, rsp_value_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [NumSignals-1:0] above;
   logic                  later;
   logic                  match;
   logic                  emit;
   logic                  last;
   logic                  stall;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      mask_in      = mask_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      update       = '0;

      for (int j = 0; j < NumSignals; j++) begin
         above[j] = (j > int'(idx_ff));
      end
      later = |(mask_ff & above);
      match = mask_ff[idx_ff];
      emit  = match && (count_ff != CountW'(MaxResults));
      last  = (count_ff == CountW'(MaxResults - 1)) || !later;
      stall = emit && rsp_valid_ff && !rsp_ready;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         StIdle: begin
            if (req_valid) begin
               mask_in  = desc_hit_mask(id_hit);
               idx_in   = '0;
               count_in = '0;
               if (|mask_in) begin
                  state_in = StScan;
               end
            end
         end
         StScan: begin
            if (!stall) begin
               update.write = match;
               update.index = idx_ff;
               if (emit) begin
                  rsp_valid_in = 1'b1;
                  rsp_index_in = idx_ff;
                  rsp_value_in = field_value;
                  rsp_last_in  = last;
                  count_in     = count_ff + CountW'(1);
               end
               if (!later) begin
                  state_in = StIdle;
               end else begin
                  idx_in = idx_ff + IdxW'(1);
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         idx_ff       <= '0;
         mask_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         mask_ff      <= mask_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_ready        = (state_ff == StIdle);
   assign desc_index       = idx_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_signal_index = rsp_index_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_last         = rsp_last_ff;

endmodule
